// File: src/spk_pkg.sv
// Shared types and constants for the sector packer with CRC-32.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package spk_pkg;

	// Fixed field widths.
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned LEN_W    = 32;
	localparam int unsigned CRC_W    = 32;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned OFFS_W   = 9;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	// Reflected CRC-32 polynomial and start value.
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hedb8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hffff_ffff;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_BYTE   = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} spk_op_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_STARTED  = 2'd2,
		ST_FINISHED = 2'd3
	} spk_status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_BLOCK = 1'd0,
		CFG_CAPACITY   = 1'd1
	} spk_cfg_idx_t;

	// One result item.
	typedef struct packed {
		spk_status_t        status;
		logic [ADDR_W-1:0]  sector_block;
		logic [OFFS_W-1:0]  byte_offset;
		logic [DATA_W-1:0]  byte_value;
		logic               sector_complete;
		logic [OFFS_W-1:0]  pad_count;
		logic [LEN_W-1:0]   total_length;
		logic [CRC_W-1:0]   payload_crc;
	} spk_result_t;

endpackage

`default_nettype wire

// File: src/sector_packer_with_crc32.sv
// Sector packer with CRC-32. Takes one item (start, payload byte or finish)
// per cycle unless out_ready holds the output, and returns one result per
// item; operation code 3 gives no result. The item is caught in an input
// register; when it moves on, the payload state and the result register are
// loaded. The state loop, holding the eight-step CRC byte update, the length
// compare and the block address add, sets the rate of one item per cycle.
// The user writes registers through cfg_we, cfg_index and cfg_data only while
// the block is idle; the block itself does not enforce this.
// Depends on spk_pkg and spk_step.
`default_nettype none

module sector_packer_with_crc32 #(
	parameter int unsigned SECTOR_BYTES = 512
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write port.
	input  wire logic                                cfg_we,
	input  wire logic [spk_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [spk_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input channel.
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          operation,
	input  wire logic [spk_pkg::DATA_W-1:0]          data_byte,
	// Output channel.
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               status,
	output logic [spk_pkg::ADDR_W-1:0]               sector_block,
	output logic [spk_pkg::OFFS_W-1:0]               byte_offset,
	output logic [spk_pkg::DATA_W-1:0]               byte_value,
	output logic                                     sector_complete,
	output logic [spk_pkg::OFFS_W-1:0]               pad_count,
	output logic [spk_pkg::LEN_W-1:0]                total_length,
	output logic [spk_pkg::CRC_W-1:0]                payload_crc
);
	import spk_pkg::*;

	logic [ADDR_W-1:0] base_block_q;
	logic [LEN_W-1:0]  capacity_q;

	logic              valid_s1;
	spk_op_t           op_s1;
	logic [DATA_W-1:0] byte_s1;

	logic              valid_s2;
	spk_result_t       res_s2;

	logic              advance;
	logic              step_valid;
	spk_result_t       step_result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_block_q <= '0;
			capacity_q   <= '0;
		end else if (cfg_we) begin
			unique case (spk_cfg_idx_t'(cfg_index))
				CFG_BASE_BLOCK: base_block_q <= cfg_data;
				CFG_CAPACITY:   capacity_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register is free or being read out.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= spk_op_t'(operation);
			byte_s1 <= data_byte;
		end
	end

	spk_step #(
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (advance),
		.op             (op_s1),
		.data           (byte_s1),
		.base_block     (base_block_q),
		.capacity_bytes (capacity_q),
		.result_valid   (step_valid),
		.result         (step_result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_result;
		end
	end

	assign out_valid       = valid_s2;
	assign status          = res_s2.status;
	assign sector_block    = res_s2.sector_block;
	assign byte_offset     = res_s2.byte_offset;
	assign byte_value      = res_s2.byte_value;
	assign sector_complete = res_s2.sector_complete;
	assign pad_count       = res_s2.pad_count;
	assign total_length    = res_s2.total_length;
	assign payload_crc     = res_s2.payload_crc;

	// With the result register empty, the block always takes a transfer.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with an empty result register");

	// Only an accepted byte can close a sector.
	a_complete_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.sector_complete |-> res_s2.status == ST_ACCEPTED)
		else $error("sector complete on a non-byte result");

	// Padding is reported by a finish only.
	a_pad_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.pad_count != '0 |-> res_s2.status == ST_FINISHED)
		else $error("pad count on a result other than finish");

endmodule

`default_nettype wire

// File: src/spk_crc_byte.sv
// One-byte update of the reflected CRC-32: eight XOR-shift steps.
// Depends on spk_pkg for the polynomial and widths.
`default_nettype none

module spk_crc_byte (
	input  wire logic [spk_pkg::CRC_W-1:0]  crc_in,
	input  wire logic [spk_pkg::DATA_W-1:0] data,
	output logic      [spk_pkg::CRC_W-1:0]  crc_out
);
	import spk_pkg::*;

	// Fold the byte into the low bits, then shift one bit a step.
	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
		for (int k = 0; k < DATA_W; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

// File: src/spk_step.sv
// Payload state (CRC, length, sector fill, full sectors) and the result
// formed for one item. Depends on spk_pkg and spk_crc_byte.
`default_nettype none

module spk_step #(
	parameter int unsigned SECTOR_BYTES = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire spk_pkg::spk_op_t              op,
	input  wire logic [spk_pkg::DATA_W-1:0]    data,
	input  wire logic [spk_pkg::ADDR_W-1:0]    base_block,
	input  wire logic [spk_pkg::LEN_W-1:0]     capacity_bytes,
	output logic                               result_valid,
	output spk_pkg::spk_result_t               result
);
	import spk_pkg::*;

	localparam int unsigned FILL_W = $clog2(SECTOR_BYTES);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SECTOR_BYTES - 1);
	localparam logic [FILL_W:0]   SECTOR_N  = (FILL_W+1)'(SECTOR_BYTES);

	logic [CRC_W-1:0]  crc_q;
	logic [LEN_W-1:0]  length_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] sectors_q;

	logic [CRC_W-1:0]  crc_next;
	logic              has_room;
	logic              last_byte;
	logic [FILL_W:0]   pad_full;

	spk_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (data),
		.crc_out (crc_next)
	);

	assign has_room  = length_q < capacity_bytes;
	assign last_byte = fill_q == FILL_LAST;
	assign pad_full  = SECTOR_N - {1'b0, fill_q};

	// Result for the item held in the input register.
	always_comb begin
		result       = '0;
		result_valid = 1'b1;
		unique case (op)
			OP_START: begin
				result.status = ST_STARTED;
			end
			OP_FINISH: begin
				result.status       = ST_FINISHED;
				result.pad_count    = (fill_q != '0) ? OFFS_W'(pad_full) : '0;
				result.total_length = length_q;
				result.payload_crc  = ~crc_q;
			end
			OP_BYTE: begin
				if (has_room) begin
					result.status          = ST_ACCEPTED;
					result.sector_block    = base_block + 32'd1 + sectors_q;
					result.byte_offset     = OFFS_W'(fill_q);
					result.byte_value      = data;
					result.sector_complete = last_byte;
					result.total_length    = length_q + 32'd1;
				end else begin
					result.status       = ST_NO_SPACE;
					result.total_length = length_q;
				end
			end
			OP_NONE: begin
				result_valid = 1'b0;
			end
			default: begin
				result_valid = 1'b0;
			end
		endcase
	end

	// State update when the item moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			length_q  <= '0;
			fill_q    <= '0;
			sectors_q <= '0;
		end else if (fire) begin
			if (op == OP_START) begin
				crc_q     <= CRC_INIT;
				length_q  <= '0;
				fill_q    <= '0;
				sectors_q <= '0;
			end else if (op == OP_BYTE && has_room) begin
				crc_q    <= crc_next;
				length_q <= length_q + 32'd1;
				if (last_byte) begin
					fill_q    <= '0;
					sectors_q <= sectors_q + 32'd1;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// The fill count never reaches a whole sector.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_LAST)
		else $error("sector fill out of range");

	// A start leaves a clean payload state behind.
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_START |=> length_q == '0 && fill_q == '0 && crc_q == CRC_INIT)
		else $error("start did not clear the payload state");

	// A rejected byte changes nothing.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_BYTE && !has_room |=> $stable(length_q) && $stable(crc_q)
			&& $stable(fill_q))
		else $error("rejected byte changed the state");

endmodule

`default_nettype wire
